[rtl/tlca_pkg.sv]
// shared types, codes and defaults for the tree lca core
// no dependencies; imported by every other file in rtl
package tlca_pkg;

    localparam int ID_W            = 10;
    localparam int STATUS_W        = 2;
    localparam int MAX_NODES_DEF   = 1024;
    localparam int LIFT_LEVELS_DEF = 10;

    localparam logic CMD_ADD   = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_UNALLOC = 2'd2;

    typedef struct packed {
        logic            cmd;
        logic [ID_W-1:0] first_node;
        logic [ID_W-1:0] second_node;
    } in_beat_t;

    typedef struct packed {
        logic [ID_W-1:0]     node_id;
        logic [STATUS_W-1:0] status;
    } out_beat_t;

    // datapath operation of one microcode step
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD_IN,
        OP_DECODE,
        OP_WR_ANC0,
        OP_CHAIN,
        OP_COMMIT,
        OP_ORDER,
        OP_LD_P,
        OP_LIFT,
        OP_RES_A,
        OP_MEET,
        OP_RES_ANC,
        OP_EMIT
    } op_t;

    // ancestor table read address selection
    typedef enum logic [2:0] {
        AR_A0,
        AR_LVL_A,
        AR_CHAIN,
        AR_LIFT,
        AR_TOP,
        AR_MEET
    } ar_t;

    // depth table read address selection
    typedef enum logic {
        DR_AB,
        DR_P
    } dr_t;

    // level counter operation
    typedef enum logic [2:0] {
        LV_HOLD,
        LV_ONE,
        LV_TOP,
        LV_INC,
        LV_DEC
    } lv_t;

    // branch condition
    typedef enum logic [3:0] {
        JC_NEVER,
        JC_ALWAYS,
        JC_NO_VALID,
        JC_ERR,
        JC_QUERY,
        JC_NOT_LAST,
        JC_LVL_NZ,
        JC_SAME,
        JC_OUT_BUSY
    } jc_t;

    typedef struct packed {
        op_t op;
        ar_t ar;
        dr_t dr;
        lv_t lv;
    } uctrl_t;

    typedef struct packed {
        logic err;
        logic query;
        logic not_last;
        logic lvl_nz;
        logic same;
    } dp_flags_t;

    typedef struct packed {
        logic      s_valid;
        logic      out_busy;
        dp_flags_t dp;
    } flags_t;

endpackage

[rtl/tlca_useq.sv]
// microcode sequencer: step counter, control rom and conditional branches
// depends on tlca_pkg
module tlca_useq
    import tlca_pkg::*;
(
    input  logic   aclk,
    input  logic   aresetn,
    input  flags_t flags,
    output uctrl_t ctrl
);

    localparam int STEP_W = 4;

    localparam logic [STEP_W-1:0] S_IDLE     = 4'd0;
    localparam logic [STEP_W-1:0] S_DECODE   = 4'd1;
    localparam logic [STEP_W-1:0] S_CMD      = 4'd2;
    localparam logic [STEP_W-1:0] S_ADD0     = 4'd3;
    localparam logic [STEP_W-1:0] S_ADD_LOOP = 4'd4;
    localparam logic [STEP_W-1:0] S_ADD_END  = 4'd5;
    localparam logic [STEP_W-1:0] S_Q0       = 4'd6;
    localparam logic [STEP_W-1:0] S_Q1       = 4'd7;
    localparam logic [STEP_W-1:0] S_Q2       = 4'd8;
    localparam logic [STEP_W-1:0] S_L1       = 4'd9;
    localparam logic [STEP_W-1:0] S_L2       = 4'd10;
    localparam logic [STEP_W-1:0] S_EQ       = 4'd11;
    localparam logic [STEP_W-1:0] S_M1       = 4'd12;
    localparam logic [STEP_W-1:0] S_M_END    = 4'd13;
    localparam logic [STEP_W-1:0] S_EMIT     = 4'd14;

    typedef struct packed {
        uctrl_t            ctrl;
        jc_t               jc;
        logic [STEP_W-1:0] tgt;
        logic [STEP_W-1:0] nxt;
    } uword_t;

    function automatic uword_t mk(input op_t op, input ar_t ar, input dr_t dr, input lv_t lv,
                                  input jc_t jc, input logic [STEP_W-1:0] tgt,
                                  input logic [STEP_W-1:0] nxt);
        uword_t w;
        w.ctrl.op = op;
        w.ctrl.ar = ar;
        w.ctrl.dr = dr;
        w.ctrl.lv = lv;
        w.jc      = jc;
        w.tgt     = tgt;
        w.nxt     = nxt;
        return w;
    endfunction

    function automatic uword_t rom(input logic [STEP_W-1:0] step);
        uword_t w;
        unique case (step)
            S_IDLE:     w = mk(OP_LOAD_IN, AR_LVL_A, DR_AB, LV_HOLD, JC_NO_VALID, S_IDLE, S_DECODE);
            S_DECODE:   w = mk(OP_DECODE,  AR_LVL_A, DR_AB, LV_HOLD, JC_ERR,      S_EMIT, S_CMD);
            S_CMD:      w = mk(OP_NONE,    AR_LVL_A, DR_AB, LV_HOLD, JC_QUERY,    S_Q0,   S_ADD0);
            S_ADD0:     w = mk(OP_WR_ANC0, AR_A0,    DR_AB, LV_ONE,  JC_NEVER,    S_IDLE, S_ADD_LOOP);
            S_ADD_LOOP: w = mk(OP_CHAIN,   AR_CHAIN, DR_AB, LV_INC,  JC_NOT_LAST, S_ADD_LOOP,
                               S_ADD_END);
            S_ADD_END:  w = mk(OP_COMMIT,  AR_LVL_A, DR_AB, LV_HOLD, JC_ALWAYS,   S_EMIT, S_IDLE);
            S_Q0:       w = mk(OP_NONE,    AR_LVL_A, DR_AB, LV_HOLD, JC_NEVER,    S_IDLE, S_Q1);
            S_Q1:       w = mk(OP_ORDER,   AR_LVL_A, DR_AB, LV_TOP,  JC_NEVER,    S_IDLE, S_Q2);
            S_Q2:       w = mk(OP_NONE,    AR_LVL_A, DR_AB, LV_HOLD, JC_NEVER,    S_IDLE, S_L1);
            S_L1:       w = mk(OP_LD_P,    AR_LVL_A, DR_P,  LV_HOLD, JC_NEVER,    S_IDLE, S_L2);
            S_L2:       w = mk(OP_LIFT,    AR_LIFT,  DR_AB, LV_DEC,  JC_LVL_NZ,   S_L1,   S_EQ);
            S_EQ:       w = mk(OP_RES_A,   AR_TOP,   DR_AB, LV_TOP,  JC_SAME,     S_EMIT, S_M1);
            S_M1:       w = mk(OP_MEET,    AR_MEET,  DR_AB, LV_DEC,  JC_LVL_NZ,   S_M1,   S_M_END);
            S_M_END:    w = mk(OP_RES_ANC, AR_LVL_A, DR_AB, LV_HOLD, JC_ALWAYS,   S_EMIT, S_IDLE);
            S_EMIT:     w = mk(OP_EMIT,    AR_LVL_A, DR_AB, LV_HOLD, JC_OUT_BUSY, S_EMIT, S_IDLE);
            default:    w = mk(OP_NONE,    AR_LVL_A, DR_AB, LV_HOLD, JC_ALWAYS,   S_IDLE, S_IDLE);
        endcase
        return w;
    endfunction

    logic [STEP_W-1:0] upc_reg;
    logic [STEP_W-1:0] upc_next;
    uword_t            word;
    logic              taken;

    always_comb begin
        word = rom(upc_reg);
        unique case (word.jc)
            JC_NEVER:    taken = 1'b0;
            JC_ALWAYS:   taken = 1'b1;
            JC_NO_VALID: taken = !flags.s_valid;
            JC_ERR:      taken = flags.dp.err;
            JC_QUERY:    taken = flags.dp.query;
            JC_NOT_LAST: taken = flags.dp.not_last;
            JC_LVL_NZ:   taken = flags.dp.lvl_nz;
            JC_SAME:     taken = flags.dp.same;
            JC_OUT_BUSY: taken = flags.out_busy;
            default:     taken = 1'b1;
        endcase
        upc_next = taken ? word.tgt : word.nxt;
    end

    assign ctrl = word.ctrl;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            upc_reg <= S_IDLE;
        end else begin
            upc_reg <= upc_next;
        end
    end

endmodule

[rtl/tlca_dp.sv]
// datapath: depth and ancestor tables, node registers and level counter
// depends on tlca_pkg; steered by the control word from tlca_useq
module tlca_dp
    import tlca_pkg::*;
#(
    parameter int MAX_NODES   = MAX_NODES_DEF,
    parameter int LIFT_LEVELS = LIFT_LEVELS_DEF
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  uctrl_t    ctrl,
    input  logic      accept,
    input  in_beat_t  s_beat,
    output dp_flags_t dp_flags,
    output out_beat_t res
);

    localparam int NODE_W = $clog2(MAX_NODES);
    localparam int LVL_W  = $clog2(LIFT_LEVELS);
    localparam int DEP_W  = NODE_W + 1;
    localparam int CMP_W  = (NODE_W > ID_W) ? NODE_W : ID_W;
    localparam logic [LVL_W-1:0] LVL_TOP = LVL_W'(LIFT_LEVELS - 1);

    logic [NODE_W-1:0]       anc_mem [LIFT_LEVELS][MAX_NODES];
    logic signed [DEP_W-1:0] dep_mem [MAX_NODES];

    in_beat_t                in_reg;
    logic [NODE_W-1:0]       a_reg;
    logic [NODE_W-1:0]       b_reg;
    logic [NODE_W-1:0]       p_reg;
    logic signed [DEP_W-1:0] db_reg;
    logic [LVL_W-1:0]        lvl_reg;
    logic [NODE_W-1:0]       last_reg;
    logic [NODE_W-1:0]       res_reg;
    logic [STATUS_W-1:0]     status_reg;

    logic [NODE_W-1:0]       anc_qx_reg;
    logic [NODE_W-1:0]       anc_qy_reg;
    logic                    ax_lo_reg;
    logic                    ay_lo_reg;
    logic signed [DEP_W-1:0] dep_qx_reg;
    logic signed [DEP_W-1:0] dep_qy_reg;
    logic                    dx_lo_reg;
    logic                    dx_b0_reg;
    logic                    dy_lo_reg;
    logic                    dy_b0_reg;

    logic [NODE_W-1:0]       anc_x;
    logic [NODE_W-1:0]       anc_y;
    logic signed [DEP_W-1:0] dep_x;
    logic signed [DEP_W-1:0] dep_y;
    logic [NODE_W-1:0]       nova;
    logic [NODE_W:0]         nova_wide;
    logic                    full;
    logic                    n1_bad;
    logic                    n2_bad;
    logic [STATUS_W-1:0]     status_calc;
    logic [LVL_W-1:0]        lvl_dn;
    logic                    ge;
    logic                    differ;
    logic [LVL_W-1:0]        ax_lvl;
    logic [NODE_W-1:0]       ax_node;
    logic [LVL_W-1:0]        ay_lvl;
    logic [NODE_W-1:0]       ay_node;
    logic [NODE_W-1:0]       dx_node;
    logic [NODE_W-1:0]       dy_node;
    logic                    anc_we;
    logic [LVL_W-1:0]        anc_wl;
    logic [NODE_W-1:0]       anc_wd;
    logic                    dep_we;

    // sentinel and root entries never live in the tables
    assign anc_x = ax_lo_reg ? '0 : anc_qx_reg;
    assign anc_y = ay_lo_reg ? '0 : anc_qy_reg;
    assign dep_x = !dx_lo_reg ? dep_qx_reg : (dx_b0_reg ? '0 : '1);
    assign dep_y = !dy_lo_reg ? dep_qy_reg : (dy_b0_reg ? '0 : '1);

    assign nova_wide = {1'b0, last_reg} + 1'b1;
    assign nova      = nova_wide[NODE_W-1:0];
    assign full      = nova_wide >= (NODE_W + 1)'(MAX_NODES);
    assign n1_bad    = CMP_W'(in_reg.first_node) > CMP_W'(last_reg);
    assign n2_bad    = CMP_W'(in_reg.second_node) > CMP_W'(last_reg);

    always_comb begin
        if (in_reg.cmd == CMD_ADD) begin
            if (full) begin
                status_calc = ST_FULL;
            end else if (n1_bad) begin
                status_calc = ST_UNALLOC;
            end else begin
                status_calc = ST_OK;
            end
        end else begin
            status_calc = (n1_bad || n2_bad) ? ST_UNALLOC : ST_OK;
        end
    end

    assign lvl_dn = (lvl_reg == '0) ? '0 : lvl_reg - 1'b1;
    assign ge     = dep_x >= db_reg;
    assign differ = anc_x != anc_y;

    always_comb begin
        ax_lvl  = lvl_reg;
        ax_node = a_reg;
        ay_lvl  = lvl_reg;
        ay_node = b_reg;
        unique case (ctrl.ar)
            AR_A0: begin
                ax_lvl = '0;
            end
            AR_LVL_A: begin
                ax_lvl = lvl_reg;
            end
            AR_CHAIN: begin
                ax_node = anc_x;
            end
            AR_LIFT: begin
                ax_lvl  = lvl_dn;
                ax_node = ge ? p_reg : a_reg;
            end
            AR_TOP: begin
                ax_lvl = LVL_TOP;
                ay_lvl = LVL_TOP;
            end
            AR_MEET: begin
                ax_lvl  = lvl_dn;
                ax_node = differ ? anc_x : a_reg;
                ay_lvl  = lvl_dn;
                ay_node = differ ? anc_y : b_reg;
            end
            default: begin
                ax_lvl = lvl_reg;
            end
        endcase
    end

    assign dx_node = (ctrl.dr == DR_P) ? anc_x : a_reg;
    assign dy_node = b_reg;

    assign anc_we = (ctrl.op == OP_WR_ANC0) || (ctrl.op == OP_CHAIN);
    assign anc_wl = (ctrl.op == OP_WR_ANC0) ? '0 : lvl_reg;
    assign anc_wd = (ctrl.op == OP_WR_ANC0) ? a_reg : anc_x;
    assign dep_we = ctrl.op == OP_CHAIN;

    // table ports
    always_ff @(posedge aclk) begin
        if (anc_we) begin
            anc_mem[anc_wl][nova] <= anc_wd;
        end
        if (dep_we) begin
            dep_mem[nova] <= dep_x + DEP_W'(1);
        end
        anc_qx_reg <= anc_mem[ax_lvl][ax_node];
        anc_qy_reg <= anc_mem[ay_lvl][ay_node];
        dep_qx_reg <= dep_mem[dx_node];
        dep_qy_reg <= dep_mem[dy_node];
        ax_lo_reg  <= ax_node[NODE_W-1:1] == '0;
        ay_lo_reg  <= ay_node[NODE_W-1:1] == '0;
        dx_lo_reg  <= dx_node[NODE_W-1:1] == '0;
        dx_b0_reg  <= dx_node[0];
        dy_lo_reg  <= dy_node[NODE_W-1:1] == '0;
        dy_b0_reg  <= dy_node[0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_reg <= NODE_W'(1);
        end else if (ctrl.op == OP_COMMIT) begin
            last_reg <= nova;
        end
    end

    always_ff @(posedge aclk) begin
        unique case (ctrl.lv)
            LV_HOLD: lvl_reg <= lvl_reg;
            LV_ONE:  lvl_reg <= LVL_W'(1);
            LV_TOP:  lvl_reg <= LVL_TOP;
            LV_INC:  lvl_reg <= lvl_reg + 1'b1;
            LV_DEC:  lvl_reg <= lvl_dn;
            default: lvl_reg <= lvl_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        unique case (ctrl.op)
            OP_LOAD_IN: begin
                if (accept) begin
                    in_reg <= s_beat;
                end
            end
            OP_DECODE: begin
                a_reg      <= NODE_W'(in_reg.first_node);
                b_reg      <= NODE_W'(in_reg.second_node);
                status_reg <= status_calc;
                res_reg    <= '0;
            end
            OP_COMMIT: begin
                res_reg <= nova;
            end
            OP_ORDER: begin
                if (dep_x < dep_y) begin
                    a_reg  <= b_reg;
                    b_reg  <= a_reg;
                    db_reg <= dep_x;
                end else begin
                    db_reg <= dep_y;
                end
            end
            OP_LD_P: begin
                p_reg <= anc_x;
            end
            OP_LIFT: begin
                if (ge) begin
                    a_reg <= p_reg;
                end
            end
            OP_RES_A: begin
                res_reg <= a_reg;
            end
            OP_MEET: begin
                if (differ) begin
                    a_reg <= anc_x;
                    b_reg <= anc_y;
                end
            end
            OP_RES_ANC: begin
                res_reg <= anc_x;
            end
            default: begin
            end
        endcase
    end

    assign dp_flags.err      = status_calc != ST_OK;
    assign dp_flags.query    = in_reg.cmd == CMD_QUERY;
    assign dp_flags.not_last = lvl_reg != LVL_TOP;
    assign dp_flags.lvl_nz   = lvl_reg != '0;
    assign dp_flags.same     = a_reg == b_reg;

    assign res.node_id = ID_W'(res_reg);
    assign res.status  = status_reg;

endmodule

[rtl/tree_lca_binary_lifting_core.sv]
// tree lca core: an add fills the new node's ancestor levels one by one; a flagged command
// goes straight to the result; a query lifts the deeper node onto the other's depth and, if
// they differ, walks both down from the top level; one beat in flight, the next is taken in
// the cycle after the result is registered, even while that result waits for m_ready
// reset (synchronous, active low) leaves only the sentinel and the root allocated
// depends on tlca_pkg, tlca_useq and tlca_dp
module tree_lca_binary_lifting_core
    import tlca_pkg::*;
#(
    parameter int MAX_NODES   = MAX_NODES_DEF,
    parameter int LIFT_LEVELS = LIFT_LEVELS_DEF
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_beat_t  s_beat,
    output logic      m_valid,
    input  logic      m_ready,
    output out_beat_t m_beat
);

    uctrl_t    ctrl;
    flags_t    flags;
    dp_flags_t dp_flags;
    out_beat_t dp_res;
    logic      accept;
    logic      out_busy;
    logic      emit;
    logic      m_valid_reg;
    out_beat_t m_beat_reg;

    assign s_ready  = ctrl.op == OP_LOAD_IN;
    assign accept   = s_valid && s_ready;
    assign out_busy = m_valid_reg && !m_ready;
    assign emit     = (ctrl.op == OP_EMIT) && !out_busy;

    assign flags.s_valid  = s_valid;
    assign flags.out_busy = out_busy;
    assign flags.dp       = dp_flags;

    tlca_useq u_useq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .flags   (flags),
        .ctrl    (ctrl)
    );

    tlca_dp #(
        .MAX_NODES   (MAX_NODES),
        .LIFT_LEVELS (LIFT_LEVELS)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctrl     (ctrl),
        .accept   (accept),
        .s_beat   (s_beat),
        .dp_flags (dp_flags),
        .res      (dp_res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            m_beat_reg <= dp_res;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_beat  = m_beat_reg;

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken again straight after a beat");

    a_error_id_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_beat.status != ST_OK |-> m_beat.node_id == '0)
        else $error("flagged result carries a node id");

    a_rise_from_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(ctrl.op == OP_EMIT))
        else $error("result raised outside the emit step");

endmodule

[verif/testbench.sv]
`timescale 1ns / 100ps
// testbench for tree_lca_binary_lifting_core: node adds and lca queries are checked against
// a binary-lifting tree predictor held in the bench, under random stalls on both sides and
// a long receiver hold-off; depends on tlca_pkg and the core rtl
module testbench;
    import tlca_pkg::*;

    localparam int TREE_NODES  = MAX_NODES_DEF;
    localparam int TREE_LEVELS = LIFT_LEVELS_DEF;
    localparam int RANDOM_CMDS = 1680;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int DRAIN_AT    = 700;
    localparam int HOLD_AT     = 250;
    localparam int HOLD_CYCLES = 400;
    localparam int TAIL_CYCLES = 60;
    localparam int PRINT_CAP   = 40;

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_beat_t  s_beat  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_beat_t m_beat;

    tree_lca_binary_lifting_core #(
        .MAX_NODES  (TREE_NODES),
        .LIFT_LEVELS(TREE_LEVELS)
    ) DUT (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_beat (s_beat),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_beat (m_beat)
    );

    always #5 aclk = ~aclk;

    logic signed [ID_W:0] tree_depth [TREE_NODES];
    logic [ID_W-1:0]      tree_up    [TREE_LEVELS][TREE_NODES];
    int unsigned          tree_last;

    in_beat_t  pending_cmds[$];
    out_beat_t expected_results[$];
    int        gen_parent [TREE_NODES];
    int        gen_last;

    int sent_cnt  = 0;
    int got_cnt   = 0;
    int err_cnt   = 0;
    int cycle_cnt = 0;
    int hold_left = 0;
    bit hold_done = 1'b0;
    int n_add     = 0;
    int n_query   = 0;
    int n_full    = 0;
    int n_unalloc = 0;
    int deepest   = 0;

    function automatic logic [ID_W-1:0] common_ancestor(input logic [ID_W-1:0] a_in,
                                                        input logic [ID_W-1:0] b_in);
        logic [ID_W-1:0] a, b, t;
        a = a_in;
        b = b_in;
        if (tree_depth[a] < tree_depth[b]) begin
            t = a;
            a = b;
            b = t;
        end
        for (int lv = TREE_LEVELS - 1; lv >= 0; lv--) begin
            if (tree_depth[tree_up[lv][a]] >= tree_depth[b])
                a = tree_up[lv][a];
        end
        if (a == b)
            return a;
        for (int lv = TREE_LEVELS - 1; lv >= 0; lv--) begin
            if (tree_up[lv][a] != tree_up[lv][b]) begin
                a = tree_up[lv][a];
                b = tree_up[lv][b];
            end
        end
        return tree_up[0][a];
    endfunction

    function automatic out_beat_t tree_apply(input in_beat_t req);
        out_beat_t   res;
        int unsigned nova;
        res  = '0;
        nova = tree_last + 1;
        if (req.cmd == CMD_ADD) begin
            if (nova >= TREE_NODES) begin
                res.status = ST_FULL;
            end else if (req.first_node > tree_last) begin
                res.status = ST_UNALLOC;
            end else begin
                tree_depth[nova] = tree_depth[req.first_node] + (ID_W + 1)'(1);
                tree_up[0][nova] = req.first_node;
                for (int lv = 1; lv < TREE_LEVELS; lv++)
                    tree_up[lv][nova] = tree_up[lv-1][tree_up[lv-1][nova]];
                tree_last      = nova;
                res.node_id    = nova[ID_W-1:0];
                res.status     = ST_OK;
            end
        end else if (req.first_node > tree_last || req.second_node > tree_last) begin
            res.status = ST_UNALLOC;
        end else begin
            res.node_id = common_ancestor(req.first_node, req.second_node);
            res.status  = ST_OK;
        end
        return res;
    endfunction

    // idle percentage of the current phase, taken from the count of accepted commands
    function automatic int idle_pct(input bit receiver);
        case ((sent_cnt / 128) % 4)
            1: return receiver ? 0 : 70;
            2: return receiver ? 70 : 0;
            3: return 13;
            default: return 0;
        endcase
    endfunction

    function automatic int pick_node();
        if ($urandom_range(1))
            return $urandom_range(gen_last, 0);
        return $urandom_range(gen_last, (gen_last > 16) ? gen_last - 16 : 0);
    endfunction

    function automatic int pick_free();
        if (gen_last < TREE_NODES - 1)
            return $urandom_range(TREE_NODES - 1, gen_last + 1);
        return gen_last;
    endfunction

    function automatic int lift_gen(input int x, input int k);
        for (int i = 0; i < k && x > 1; i++)
            x = gen_parent[x];
        return x;
    endfunction

    task automatic queue_cmd(input logic cmd, input int a, input int b);
        in_beat_t c;
        c.cmd         = cmd;
        c.first_node  = a[ID_W-1:0];
        c.second_node = b[ID_W-1:0];
        pending_cmds.push_back(c);
        if (cmd == CMD_ADD && gen_last < TREE_NODES - 1 && a <= gen_last) begin
            gen_last++;
            gen_parent[gen_last] = a;
        end
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        if (err_cnt < PRINT_CAP)
            $display("mismatch at result %0d: %s got %0d expected %0d", got_cnt, what, got, want);
        err_cnt++;
    endtask

    // driver
    always @(posedge aclk) begin
        out_beat_t want;
        bit        draining;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                want = tree_apply(s_beat);
                expected_results.push_back(want);
                sent_cnt++;
                if (want.status == ST_FULL) begin
                    n_full++;
                end else if (want.status == ST_UNALLOC) begin
                    n_unalloc++;
                end else if (s_beat.cmd == CMD_ADD) begin
                    n_add++;
                    if (int'(tree_depth[want.node_id]) > deepest)
                        deepest = int'(tree_depth[want.node_id]);
                end else begin
                    n_query++;
                end
            end
            draining = (sent_cnt == DRAIN_AT) && (expected_results.size() != 0);
            if (!s_valid || s_ready) begin
                if (pending_cmds.size() != 0 && !draining &&
                    !(hold_left == 0 && $urandom_range(99) < idle_pct(1'b0))) begin
                    s_valid <= 1'b1;
                    s_beat  <= pending_cmds.pop_front();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge aclk) begin
        out_beat_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                got_cnt++;
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected beat, node_id", m_beat.node_id, -1);
                end else begin
                    want = expected_results.pop_front();
                    if (m_beat.node_id !== want.node_id)
                        report_mismatch("node_id", m_beat.node_id, want.node_id);
                    if (m_beat.status !== want.status)
                        report_mismatch("status", m_beat.status, want.status);
                end
            end
            m_ready <= (hold_left == 0) && ($urandom_range(99) >= idle_pct(1'b1));
        end
    end

    // long receiver hold-off so the core backs up and stalls its input
    always @(posedge aclk) begin
        if (!aresetn) begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (!hold_done && got_cnt >= HOLD_AT) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding", cycle_cnt,
                     expected_results.size());
            $display("testbench NOT OK");
            $finish;
        end
    end

    initial begin
        int a, b, roll;
        bit swap;
        for (int n = 0; n < TREE_NODES; n++) begin
            tree_depth[n] = '0;
            gen_parent[n] = 0;
            for (int lv = 0; lv < TREE_LEVELS; lv++)
                tree_up[lv][n] = '0;
        end
        tree_depth[0] = '1;
        tree_last     = 1;
        gen_last      = 1;

        // directed: sentinel, root, flagged ids, add under the sentinel, ancestor pairs
        queue_cmd(CMD_QUERY, 1, 1);
        queue_cmd(CMD_QUERY, 0, 1);
        queue_cmd(CMD_QUERY, 0, 0);
        queue_cmd(CMD_QUERY, 2, 1);
        queue_cmd(CMD_QUERY, 1, TREE_NODES - 1);
        queue_cmd(CMD_ADD, TREE_NODES - 1, 0);
        queue_cmd(CMD_ADD, 2, 0);
        queue_cmd(CMD_ADD, 1, TREE_NODES - 1);
        queue_cmd(CMD_ADD, 2, 0);
        queue_cmd(CMD_ADD, 1, 0);
        queue_cmd(CMD_ADD, 0, 0);
        queue_cmd(CMD_ADD, 5, 0);
        queue_cmd(CMD_QUERY, 3, 4);
        queue_cmd(CMD_QUERY, 3, 6);
        queue_cmd(CMD_QUERY, 3, 2);
        queue_cmd(CMD_QUERY, 6, 0);
        queue_cmd(CMD_QUERY, 4, 4);
        queue_cmd(CMD_QUERY, 7, 3);
        queue_cmd(CMD_QUERY, 6, 5);
        queue_cmd(CMD_QUERY, TREE_NODES - 1, TREE_NODES - 1);

        for (int i = 0; i < RANDOM_CMDS; i++) begin
            roll = $urandom_range(99);
            if (roll < ((gen_last < TREE_NODES - 1) ? 70 : 15)) begin
                roll = $urandom_range(99);
                if (roll < 55)
                    a = gen_last;
                else if (roll < 63)
                    a = 0;
                else if (roll < 68)
                    a = pick_free();
                else
                    a = pick_node();
                queue_cmd(CMD_ADD, a, $urandom_range(TREE_NODES - 1));
            end else begin
                roll = $urandom_range(99);
                swap = $urandom_range(1);
                a    = pick_node();
                b    = pick_node();
                if (roll < 10)
                    a = pick_free();
                else if (roll < 25)
                    b = lift_gen(a, $urandom_range(700));
                else if (roll < 30)
                    b = a;
                else if (roll < 35)
                    b = 0;
                queue_cmd(CMD_QUERY, swap ? b : a, swap ? a : b);
            end
        end

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        while (pending_cmds.size() != 0 || s_valid || expected_results.size() != 0)
            @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("%0d commands, %0d results: %0d nodes added (deepest %0d), %0d lca answers",
                 sent_cnt, got_cnt, n_add, deepest, n_query);
        $display("flagged: %0d table full, %0d unallocated id; %0d mismatches",
                 n_full, n_unalloc, err_cnt);
        if (err_cnt == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule
